// ===== rtl/kmes_pkg.sv =====
// Shared constants for the keypad matrix edge scanner.
// No dependencies; imported by kmes_prev_store, keypad_matrix_edge_scanner_core and the testbench.
`timescale 1ns / 1ps

package kmes_pkg;

   localparam int ROW_W      = 5;      // row pins per column reading
   localparam int KEY_CODE_W = 7;      // key code field width
   localparam int ROW_IDX_W  = 3;      // enough for a row number below ROW_W
   localparam int DEF_COLUMNS = 20;
   localparam int KP_ROWS    = 5;      // rows that can report a press

   localparam logic [ROW_W-1:0] ROW_MASK = 5'h1f;

   // usable-row mask: bits at or above KP_ROWS never count as presses
   localparam logic [ROW_W-1:0] ROW_USE_MASK =
      ROW_MASK >> (ROW_W - ((KP_ROWS < ROW_W) ? KP_ROWS : ROW_W));

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

endpackage

// ===== rtl/kmes_prev_store.sv =====
// Previous-reading store: one row reading per column in a synchronous memory.
// Per-column valid bits clear every column at once; write-to-read bypass for the
// same column. Depends on kmes_pkg.
`timescale 1ns / 1ps

module kmes_prev_store #(
   parameter int COLUMNS = kmes_pkg::DEF_COLUMNS,
   parameter int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [COL_W-1:0]         rd_col,
   input  logic                     wr_en,
   input  logic [COL_W-1:0]         wr_col,
   input  logic [kmes_pkg::ROW_W-1:0] wr_data,
   input  logic                     clear,
   output logic [kmes_pkg::ROW_W-1:0] rd_data
);
   import kmes_pkg::*;

   logic [ROW_W-1:0] mem [COLUMNS];
   logic [ROW_W-1:0] mem_q_ff;
   logic [COL_W-1:0] rd_col_ff;
   logic             byp_ff;
   logic [ROW_W-1:0] byp_data_ff;
   logic [COLUMNS-1:0] valid_ff;
   logic [COLUMNS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_col] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_col];
         rd_col_ff   <= rd_col;
         byp_ff      <= wr_en && (wr_col == rd_col);
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_col] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // never-written or cleared column reads as all open
   always_comb begin
      if (!valid_ff[rd_col_ff]) begin
         rd_data = '0;
      end else if (byp_ff) begin
         rd_data = byp_data_ff;
      end else begin
         rd_data = mem_q_ff;
      end
   end

endmodule

// ===== rtl/keypad_matrix_edge_scanner_core.sv =====
// Keypad matrix edge scanner, top level.
// Depends on kmes_pkg and kmes_prev_store.
`timescale 1ns / 1ps

// Usage:
//  req channel: one beat per scanned column, columns in order 0..COLUMNS-1.
//    req_tuser = command (0 sample, 1 clear the previous-reading store).
//    req_tdata = row pin levels, active low, one bit per row.
//  rsp channel: one beat after the last column of each scan.
//    rsp_tuser = key_valid, rsp_tdata = key_code (row * COLUMNS + column,
//    zero when no new press). Later column wins, then higher row.
//  A clear beat gives no result and keeps the scan position.
//  Throughput: one beat per cycle while req_tready is high. Path: the last
//  column beat is accepted and the memory read, then the compare/write-back
//  stage (a receiver stall can hold it) loads the output register and raises rsp_tvalid.
//  The stored readings sit in a one-port-write, one-port-read memory read
//  at accept and written back from the compare/write-back stage; a
//  same-column bypass covers back-to-back accesses.
//  Reset clears the scan position, the partial result and all stored
//  readings (per-column valid bits), at once; no sweep is needed.
//  Receiver stall: the output register holds its beat; column beats keep
//  flowing until a second scan result is ready, then req_tready drops.
module keypad_matrix_edge_scanner_core #(
   parameter int COLUMNS = kmes_pkg::DEF_COLUMNS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] row_levels, [7:5] zero
   input  logic       req_tuser,   // [0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] key_code, [7] zero
   output logic       rsp_tuser    // [0] key_valid
);
   import kmes_pkg::*;

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PROD_W = ROW_IDX_W + COL_W + 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   // accept stage
   logic             req_acc;
   logic [COL_W-1:0] col_ff, col_in;
   logic             col_last;

   // compare / write-back stage
   logic             s1_valid_ff;
   cmd_type          s1_cmd_ff;
   logic [ROW_W-1:0] s1_now_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_last_ff;
   logic             s1_go;
   logic             s1_sample;

   logic [ROW_W-1:0] prev_rows;
   logic [ROW_W-1:0] fresh;
   logic [ROW_IDX_W-1:0] hi_row;
   logic [PROD_W-1:0]    code_wide;
   logic [KEY_CODE_W-1:0] code;

   logic                  found_ff, found_in;
   logic [KEY_CODE_W-1:0] best_ff, best_in;

   logic                  rsp_valid_ff;
   logic                  rsp_key_valid_ff;
   logic [KEY_CODE_W-1:0] rsp_code_ff;

   assign col_last = (col_ff == LAST_COL);
   assign req_acc  = req_tvalid && req_tready;

   // stage 1 holds only a finishing sample whose result cannot land
   assign s1_go = s1_valid_ff &&
                  ((s1_cmd_ff == CMD_CLEAR) || !s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign s1_sample  = s1_go && (s1_cmd_ff == CMD_SAMPLE);

   always_comb begin
      col_in = col_ff;
      if (req_acc && (cmd_type'(req_tuser) == CMD_SAMPLE)) begin
         col_in = col_last ? '0 : col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff  <= cmd_type'(req_tuser);
         s1_now_ff  <= ~req_tdata[ROW_W-1:0] & ROW_MASK;
         s1_col_ff  <= col_ff;
         s1_last_ff <= col_last;
      end
   end

   kmes_prev_store #(
      .COLUMNS (COLUMNS),
      .COL_W   (COL_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_col  (col_ff),
      .wr_en   (s1_sample),
      .wr_col  (s1_col_ff),
      .wr_data (s1_now_ff),
      .clear   (s1_go && (s1_cmd_ff == CMD_CLEAR)),
      .rd_data (prev_rows)
   );

   // newly closed rows, highest one wins
   assign fresh = s1_now_ff & ~prev_rows & ROW_USE_MASK;

   always_comb begin
      hi_row = '0;
      for (int r = 0; r < ROW_W; r++) begin
         if (fresh[r]) begin
            hi_row = ROW_IDX_W'(r);
         end
      end
   end

   assign code_wide = PROD_W'(hi_row) * PROD_W'(COLUMNS) + PROD_W'(s1_col_ff);
   assign code      = code_wide[KEY_CODE_W-1:0];

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (s1_sample) begin
         if (s1_last_ff) begin
            found_in = 1'b0;
            best_in  = '0;
         end else if (|fresh) begin
            found_in = 1'b1;
            best_in  = code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         best_ff  <= best_in;
         if (s1_sample && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result beat: last column's press beats anything found earlier
   always_ff @(posedge clock) begin
      if (s1_sample && s1_last_ff) begin
         rsp_key_valid_ff <= found_ff || (|fresh);
         priority if (|fresh) begin
            rsp_code_ff <= code;
         end else if (found_ff) begin
            rsp_code_ff <= best_ff;
         end else begin
            rsp_code_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_key_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_code_ff};

`ifndef SYNTH
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("column counter out of range");

   a_no_key_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("no-press result carries a nonzero code");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && s1_valid_ff && s1_last_ff &&
      (s1_cmd_ff == CMD_SAMPLE) |-> !s1_go)
      else $error("pending result would be overwritten");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("stalled column lost");
`endif

endmodule

// ===== tb/keypad_matrix_edge_scanner_core_test.sv =====
// Self-checking testbench for keypad_matrix_edge_scanner_core.
// Depends on kmes_pkg and the scanner RTL. Scan results are checked against an
// in-bench scan predictor, with random idling and a long receiver stall.
`timescale 1ns / 1ps

module keypad_matrix_edge_scanner_core_test;

   import kmes_pkg::*;

   localparam int SCAN_COLS  = DEF_COLUMNS;
   localparam int LONG_STALL = 400;     // receiver hold-off, cycles
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                  key_valid;
      logic [KEY_CODE_W-1:0] key_code;
   } scan_result_type;

   // DUT ports; every input starts at a known value
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [4:0] row_levels, [7:5] zero
   logic       req_tuser = 1'b0;    // [0] command
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] key_code, [7] zero
   logic       rsp_tuser;           // [0] key_valid

   // predictor state
   logic [ROW_W-1:0]      closed_rows[SCAN_COLS];
   int unsigned           scan_col;
   logic                  press_seen;
   logic [KEY_CODE_W-1:0] winner_code;
   scan_result_type       pending_scans[$];

   // traffic shaping
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_idle_pct = 0;
   int unsigned           stall_token = 0;
   int unsigned           stall_seen = 0;
   int unsigned           stall_left = 0;
   logic [ROW_W-1:0]      held_levels[SCAN_COLS];   // pin pattern the keypad shows
   int unsigned           pattern_col = 0;
   int unsigned           error_count = 0;

   keypad_matrix_edge_scanner_core #(
      .COLUMNS(SCAN_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scan predictor: one call per accepted column beat.
   // Clear wipes the stored readings only; scan position and partial winner
   // survive. A new press is a row closed now but open in the stored reading.
   // Later column wins, then higher row, so the last hit in order wins.
   // ---------------------------------------------------------------------
   function automatic void predict_column(cmd_type cmd, logic [ROW_W-1:0] levels);
      logic [ROW_W-1:0] closed_now;
      logic [ROW_W-1:0] fresh;
      scan_result_type  res;
      closed_now = ~levels & ROW_MASK;
      if (cmd == CMD_CLEAR) begin
         foreach (closed_rows[c]) closed_rows[c] = '0;
         return;
      end
      fresh = closed_now & ~closed_rows[scan_col] & ROW_USE_MASK;
      for (int r = 0; r < KP_ROWS; r++) begin
         if (fresh[r]) begin
            press_seen  = 1'b1;
            winner_code = KEY_CODE_W'(r * SCAN_COLS + scan_col);
         end
      end
      closed_rows[scan_col] = closed_now;
      if (scan_col == SCAN_COLS - 1) begin
         res.key_valid = press_seen;
         res.key_code  = press_seen ? winner_code : '0;
         pending_scans.push_back(res);
         scan_col    = 0;
         press_seen  = 1'b0;
         winner_code = '0;
      end else begin
         scan_col++;
      end
   endfunction

   // Offer one beat; sender gaps are per-cycle coin flips so they land on any
   // column. Valid is left high on return so back-to-back beats need no toggle.
   task automatic send_beat(cmd_type cmd, logic [ROW_W-1:0] levels);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, levels};
      do @(posedge clock); while (!req_tready);
      predict_column(cmd, levels);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Sample beat for the next column of the keypad pattern.
   task automatic send_column(logic [ROW_W-1:0] levels);
      held_levels[pattern_col] = levels;
      send_beat(CMD_SAMPLE, levels);
      pattern_col = (pattern_col + 1) % SCAN_COLS;
   endtask

   // ---------------------------------------------------------------------
   // Result side: compare each accepted beat with the oldest expected scan.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scans.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected scan result: valid %0b code %0d",
                        rsp_tuser, rsp_tdata);
         end else begin
            want = pending_scans.pop_front();
            if (rsp_tuser !== want.key_valid || rsp_tdata !== {1'b0, want.key_code}) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("scan result mismatch: expected valid %0b code %0d, got valid %0b tdata %0d",
                           want.key_valid, want.key_code, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   // Receiver: pick next cycle's tready, forced low during a requested stall.
   always @(posedge clock) begin
      if (stall_token != stall_seen) begin
         stall_seen = stall_token;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Two scans. First: every column has presses, col 0 all rows closed, col 19
   // only row 0 -> later column wins with a low row (code 19). A clear beat sits
   // mid-scan and must not move the column. Second: columns 0..9 released,
   // 10..19 held -> no new press, result valid 0 code 0.
   task automatic test_directed();
      for (int c = 0; c < SCAN_COLS; c++) begin
         if (c == 10) send_beat(CMD_CLEAR, 5'h1f);
         if (c == 0)               send_column(5'h00);
         else if (c == SCAN_COLS - 1) send_column(5'h1e);
         else                      send_column(ROW_W'(~(1 << (c % ROW_W))));
      end
      for (int c = 0; c < SCAN_COLS; c++) begin
         if (c < 10) send_column(5'h1f);
         else        send_column(held_levels[c]);
      end
   endtask

   // Keypad-like traffic: patterns mostly held, keys toggling now and then,
   // some all-closed / all-open columns, and the odd clear with junk levels.
   task automatic test_random_scans(int beats);
      int unsigned roll;
      logic [ROW_W-1:0] lv;
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(99) < 4) begin
            send_beat(CMD_CLEAR, ROW_W'($urandom));
         end else begin
            roll = $urandom_range(99);
            lv   = held_levels[pattern_col];
            if (roll < 20)      lv = ROW_W'($urandom);
            else if (roll < 25) lv = 5'h00;
            else if (roll < 30) lv = 5'h1f;
            else if (roll < 40) lv = lv ^ ROW_W'(1 << $urandom_range(ROW_W - 1));
            send_column(lv);
         end
      end
   endtask

   // Receiver holds off for a long stretch while columns keep coming, so the
   // output fills and req_tready must drop until the stall ends.
   task automatic test_backpressure();
      stall_token++;
      test_random_scans(3 * SCAN_COLS + 7);
   endtask

   initial begin
      foreach (closed_rows[c]) closed_rows[c] = '0;
      foreach (held_levels[c]) held_levels[c] = 5'h1f;
      scan_col    = 0;
      press_seen  = 1'b0;
      winner_code = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 63;
      test_directed();
      test_random_scans(215);

      send_idle_pct = 63;
      recv_idle_pct = 9;
      test_random_scans(215);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_scans(215);
      test_backpressure();
      stop_sending();

      while (pending_scans.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end

endmodule
